FILE: rtl/fzci_pkg.sv
// fzci_pkg: shared widths, item types and controller/datapath bundles
// of the falling zero-crossing interval core
// no dependencies
package fzci_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 16;
    localparam int EDGE_W   = 40;
    localparam int FREQ_W   = 20;
    localparam int MID_W    = 41;
    localparam int FREQ_Q   = 4;

    // default geometry of the position word
    localparam int INDEX_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd4000;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [EDGE_W-1:0] edge_position;
        logic              has_interval;
        logic [FREQ_W-1:0] interval_frequency;
        logic [MID_W-1:0]  mid_position;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic take_plain;
        logic take_cross;
        logic latch_pos;
        logic start_freq;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic crossing;
        logic div_busy;
        logic div_done;
        logic edge_seen;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/fzci_ifs.sv
// fzci channel interfaces: sample input, result output, rate write
// depends on fzci_pkg for the item types
interface fzci_in_if;
    import fzci_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fzci_out_if;
    import fzci_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fzci_cfg_if;
    import fzci_pkg::*;
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fzci_div.sv
// fzci_div: shared restoring divider, one quotient bit per cycle
// no package dependencies
module fzci_div #(
    parameter int DW = 40,
    parameter int NW = 36
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_rem_init,
    input  logic [NW-1:0]            i_numer,
    input  logic [DW-1:0]            i_denom,
    input  logic [$clog2(NW+1)-1:0]  i_steps,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [NW-1:0]            o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_nq;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_nq;

    // one restoring step: numerator bits shift out, quotient bits shift in
    always_comb begin
        w_shift = {r_rem, r_nq[NW-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
        n_nq    = {r_nq[NW-2:0], w_ge};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) begin
                r_cnt <= i_steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_den <= i_denom;
            r_nq  <= i_numer;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_quot = r_nq;

`ifndef NO_ASSERTIONS
    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider started while busy");
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0))
        else $error("divider done with steps left");
    a_count_down : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("divider step count skipped");
`endif

endmodule

FILE: rtl/fzci_dp.sv
// fzci_dp: crossing state, divider operands, position math and result register
// depends on fzci_pkg and fzci_div
module fzci_dp #(
    parameter int INDEX_BITS = fzci_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = fzci_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fzci_pkg::t_in_item          i_in_item,
    input  logic                        i_cfg_valid,
    input  logic [fzci_pkg::RATE_W-1:0] i_cfg_rate,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output fzci_pkg::t_out_item         o_out_item,
    input  fzci_pkg::t_dp_cmd           i_cmd,
    output fzci_pkg::t_dp_sts           o_sts
);
    import fzci_pkg::*;

    localparam int POS_BITS = INDEX_BITS + FRAC_BITS;
    localparam int DW       = POS_BITS;
    localparam int NW       = RATE_W + FREQ_Q + FRAC_BITS;
    localparam int CW       = $clog2(NW + 1);

    // block state
    logic signed [SAMPLE_W-1:0] r_prev_sample;
    logic                       r_prev_valid;
    logic [INDEX_BITS-1:0]      r_index;
    logic [POS_BITS-1:0]        r_prev_edge;
    logic                       r_edge_seen;
    logic [RATE_W-1:0]          r_rate;

    // item in flight
    logic signed [SAMPLE_W-1:0] r_cur;
    logic                       r_last;
    logic [POS_BITS-1:0]        r_pos;

    // result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic signed [SAMPLE_W-1:0] w_cur;
    logic [SAMPLE_W:0]          w_diff;
    logic [DW+SAMPLE_W-1:0]     w_p_wide;
    logic [DW+SAMPLE_W-1:0]     w_d_wide;
    logic [POS_BITS-1:0]        w_pos;
    logic [POS_BITS-1:0]        w_spacing;
    logic [POS_BITS:0]          w_mid_sum;
    logic [POS_BITS+EDGE_W-1:0] w_edge_wide;
    logic [POS_BITS+MID_W:0]    w_mid_wide;
    logic                       w_sat;
    logic [FREQ_W-1:0]          w_freq;

    logic          w_div_start;
    logic [DW-1:0] w_div_rem;
    logic [NW-1:0] w_div_numer;
    logic [DW-1:0] w_div_denom;
    logic [CW-1:0] w_div_steps;
    logic          w_div_busy;
    logic          w_div_done;
    logic [NW-1:0] w_div_quot;

    // operands for the fraction p / (p - c)
    assign w_cur    = i_in_item.sample;
    assign w_diff   = {r_prev_sample[SAMPLE_W-1], r_prev_sample} - {w_cur[SAMPLE_W-1], w_cur};
    assign w_p_wide = {{DW{1'b0}}, r_prev_sample};
    assign w_d_wide = {{DW{1'b0}}, w_diff[SAMPLE_W-1:0]};

    // position is the index with the fraction below it, spacing to the last crossing
    assign w_pos     = {r_index, w_div_quot[FRAC_BITS-1:0]};
    assign w_spacing = w_pos - r_prev_edge;

    // divider operand select: fraction on a crossing, frequency afterwards
    always_comb begin
        w_div_start = i_cmd.take_cross | i_cmd.start_freq;
        if (i_cmd.take_cross) begin
            w_div_rem   = w_p_wide[DW-1:0];
            w_div_numer = '0;
            w_div_denom = w_d_wide[DW-1:0];
            w_div_steps = CW'(FRAC_BITS);
        end else begin
            w_div_rem   = '0;
            w_div_numer = {r_rate, {(FREQ_Q + FRAC_BITS){1'b0}}};
            w_div_denom = w_spacing;
            w_div_steps = CW'(NW);
        end
    end

    fzci_div #(
        .DW (DW),
        .NW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init (w_div_rem),
        .i_numer    (w_div_numer),
        .i_denom    (w_div_denom),
        .i_steps    (w_div_steps),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // result fields
    always_comb begin
        w_sat       = |w_div_quot[NW-1:FREQ_W];
        w_freq      = w_sat ? FREQ_MAX : w_div_quot[FREQ_W-1:0];
        w_mid_sum   = {1'b0, r_pos} + {1'b0, r_prev_edge};
        w_edge_wide = {{EDGE_W{1'b0}}, r_pos};
        w_mid_wide  = {{MID_W{1'b0}}, w_mid_sum};
        n_out.edge_position      = w_edge_wide[EDGE_W-1:0];
        n_out.has_interval       = r_edge_seen;
        n_out.interval_frequency = r_edge_seen ? w_freq : '0;
        n_out.mid_position       = r_edge_seen ? w_mid_wide[MID_W-1:0] : '0;
    end

    // control state of the block and the rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_index      <= '0;
            r_edge_seen  <= 1'b0;
            r_rate       <= RATE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rate <= i_cfg_rate;
            end
            if (i_cmd.take_plain) begin
                r_prev_valid <= ~i_in_item.last_sample;
                r_index      <= i_in_item.last_sample ? '0 : r_index + 1'b1;
                if (i_in_item.last_sample) begin
                    r_edge_seen <= 1'b0;
                end
            end else if (i_cmd.emit) begin
                r_prev_valid <= ~r_last;
                r_index      <= r_last ? '0 : r_index + 1'b1;
                r_edge_seen  <= ~r_last;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_plain) begin
            r_prev_sample <= w_cur;
        end else if (i_cmd.emit) begin
            r_prev_sample <= r_cur;
            r_prev_edge   <= r_pos;
        end
        if (i_cmd.take_cross) begin
            r_cur  <= w_cur;
            r_last <= i_in_item.last_sample;
        end
        if (i_cmd.latch_pos) begin
            r_pos <= w_pos;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.crossing  = r_prev_valid && (r_prev_sample > 0) && (w_cur < 0);
        o_sts.div_busy  = w_div_busy;
        o_sts.div_done  = w_div_done;
        o_sts.edge_seen = r_edge_seen;
        o_sts.out_free  = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_edge_needs_prev : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_seen |-> r_prev_valid)
        else $error("crossing recorded without a previous sample");
    a_frac_below_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch_pos |-> (w_div_quot[NW-1:FRAC_BITS] == '0))
        else $error("interpolation fraction not below one");
    a_no_interval_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.has_interval) |->
        (r_out.interval_frequency == '0 && r_out.mid_position == '0))
        else $error("interval fields set on a first crossing");
`endif

endmodule

FILE: rtl/fzci_ctrl.sv
// fzci_ctrl: sequencer for fraction division, frequency division and result load
// depends on fzci_pkg
module fzci_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fzci_pkg::t_dp_sts i_sts,
    output fzci_pkg::t_dp_cmd o_cmd
);
    import fzci_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRAC,
        S_FREQ,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.crossing) begin
                        o_cmd.take_cross = 1'b1;
                        n_state          = S_FRAC;
                    end else begin
                        o_cmd.take_plain = 1'b1;
                    end
                end
            end
            S_FRAC: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_pos = 1'b1;
                    if (i_sts.edge_seen) begin
                        o_cmd.start_freq = 1'b1;
                        n_state          = S_FREQ;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FREQ: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_done_when_waiting : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> !i_sts.div_done)
        else $error("divider finished with no division pending");
    a_div_running : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAC || r_state == S_FREQ) |-> (i_sts.div_busy || i_sts.div_done))
        else $error("waiting on an idle divider");
    a_freq_has_prev : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREQ) |-> i_sts.edge_seen)
        else $error("frequency division without a previous crossing");
`endif

endmodule

FILE: rtl/falling_zero_crossing_interval_core.sv
// Sequence: a sample without a crossing is taken straight from idle; a crossing runs
// fraction division, then frequency division once a previous crossing exists, then
// the result load; both divisions run one after the other on the shared serial divider.
// Throughput: one sample per cycle between crossings; a crossing occupies the core
// until its result is loaded, which waits for the output register to be free.
// Reset (synchronous, active low) clears block state and sets sample_rate to 4000.
module falling_zero_crossing_interval_core #(
    parameter int INDEX_BITS = fzci_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = fzci_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fzci_in_if.sink           i_in_ch,
    fzci_out_if.source        o_out_ch,
    fzci_cfg_if.sink          i_cfg_ch
);
    import fzci_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;
    logic      w_in_ready;
    logic      w_out_valid;
    t_out_item w_out_item;

    fzci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fzci_dp #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_ch.data),
        .i_cfg_valid (i_cfg_ch.valid),
        .i_cfg_rate  (i_cfg_ch.data),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    // channel hookup; rate writes always transfer
    assign i_in_ch.ready  = w_in_ready;
    assign i_cfg_ch.ready = 1'b1;
    assign o_out_ch.valid = w_out_valid;
    assign o_out_ch.data  = w_out_item;

endmodule
